/* rtl/core/named_segment_range_allocator_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef NAMED_SEGMENT_RANGE_ALLOCATOR_MACROS_SVH
`define NAMED_SEGMENT_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define NSRA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define NSRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

/* rtl/core/nsra_pkg.sv */
// shared types and constants of the segment range allocator
`default_nettype none
package nsra_pkg;

  localparam int MEM_WORDS    = 1024;
  localparam int MAX_FREE_DEF = 16;
  localparam int MAX_SEGS_DEF = 16;
  localparam int ADDR_W       = 10;
  localparam int LEN_W        = 11;
  localparam int END_W        = 12;
  localparam int ID_W         = 4;
  localparam int IDX_W        = 9;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_INUSE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_DROP,
    SH_INS
  } shift_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ent_t;

  typedef struct packed {
    logic             rotate;
    logic             apply;
    logic             mod_en;
    logic [IDX_W-1:0] mod_idx;
    ent_t             mod_val;
    shift_t           shift;
    logic [IDX_W-1:0] shift_idx;
    ent_t             ins_val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/nsra_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module nsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule
`default_nettype wire

/* rtl/core/nsra_cell.sv */
// one free-table cell: holds a range, rotates, shifts or updates in place
`default_nettype none
module nsra_cell #(
  parameter int IDX      = 0,
  parameter bit HAS_INIT = 1'b0
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire nsra_pkg::cell_ctrl_t   ctrl,
  input  wire nsra_pkg::ent_t         from_prev,
  input  wire nsra_pkg::ent_t         from_next,
  output nsra_pkg::ent_t              ent_r
);

  localparam logic [nsra_pkg::IDX_W-1:0] MY_IDX = nsra_pkg::IDX_W'(IDX);
  localparam nsra_pkg::ent_t INIT_ENT = '{
    start: '0,
    len:   nsra_pkg::LEN_W'(nsra_pkg::MEM_WORDS)
  };

  nsra_pkg::ent_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.rotate) begin
      ent_nxt = from_next;
    end else if (ctrl.apply) begin
      priority if (ctrl.shift == nsra_pkg::SH_DROP && MY_IDX >= ctrl.shift_idx) begin
        ent_nxt = from_next;
      end else if (ctrl.shift == nsra_pkg::SH_INS && MY_IDX > ctrl.shift_idx) begin
        ent_nxt = from_prev;
      end else if (ctrl.shift == nsra_pkg::SH_INS && MY_IDX == ctrl.shift_idx) begin
        ent_nxt = ctrl.ins_val;
      end else if (ctrl.mod_en && MY_IDX == ctrl.mod_idx) begin
        ent_nxt = ctrl.mod_val;
      end else begin
        ent_nxt = ent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n && HAS_INIT) begin
      ent_r <= INIT_ENT;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/named_segment_range_allocator.sv */
// top level of the segment range allocator: control, segment table, cell row
//
// Usage: drive in_mode, in_seg_id, in_base and in_length with start high while
// busy is low; that edge takes the request beat (create when in_mode is 0,
// remove when 1). One result beat follows, shown for exactly one cycle with
// out_strobe high: out_status, out_seg_base, out_seg_length.
// Sequence: a request rejected on its identifier or length alone (out of range,
// id in use, zero length, unknown id) answers from the lookup state, and busy
// drops as its result beat is shown. Any other request goes through the segment
// table read, a scan in which the free-range cells rotate once round their ring
// past the head compare, an apply step in which every cell updates in parallel,
// and the result register.
// A new request is taken in the cycle the result beat is shown.
// Reset (synchronous, rst_n low) leaves one free range covering all memory,
// no segments allocated. The receiver cannot stall: results are never held.
`default_nettype none
`include "named_segment_range_allocator_macros.svh"
module named_segment_range_allocator #(
  parameter int MAX_FREE = nsra_pkg::MAX_FREE_DEF,
  parameter int MAX_SEGS = nsra_pkg::MAX_SEGS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_mode,
  input  wire logic [nsra_pkg::ID_W-1:0]   in_seg_id,
  input  wire logic [nsra_pkg::ADDR_W-1:0] in_base,
  input  wire logic [nsra_pkg::LEN_W-1:0]  in_length,
  output logic                             out_strobe,
  output logic [2:0]                       out_status,
  output logic [nsra_pkg::ADDR_W-1:0]      out_seg_base,
  output logic [nsra_pkg::LEN_W-1:0]       out_seg_length
);

  localparam int CW = $clog2(MAX_FREE + 1);
  localparam int SW = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam logic [CW-1:0] KLAST = CW'(MAX_FREE - 1);
  localparam logic [CW-1:0] CMAX  = CW'(MAX_FREE);
  localparam int AW = nsra_pkg::ADDR_W;
  localparam int LW = nsra_pkg::LEN_W;
  localparam int EW = nsra_pkg::END_W;
  localparam int IW = nsra_pkg::IDX_W;

  nsra_pkg::state_t   state_r, state_nxt;
  nsra_pkg::cell_ctrl_t ctrl;
  nsra_pkg::ent_t     cells_q [MAX_FREE];
  nsra_pkg::ent_t     head;
  nsra_pkg::ent_t     ram_rdata;
  nsra_pkg::ent_t     prev_r, nxt_r;
  nsra_pkg::status_t  early_st, dec_st, out_status_r;

  logic [CW-1:0]   cnt_r, cnt_nxt, k_r, p_r;
  logic            mode_r, hit_r;
  logic [nsra_pkg::ID_W-1:0] id_r;
  logic [AW-1:0]   s_r, fs_r;
  logic [LW-1:0]   l_r;
  logic [EW-1:0]   fe_r, e_w, head_end, prev_end;
  logic [MAX_SEGS-1:0] seg_valid_r;
  logic [SW-1:0]   ram_addr, id_idx;
  logic            ram_we, id_ok, vbit, in_range, left, right, accept;
  logic            out_strobe_r;
  logic [AW-1:0]   out_seg_base_r;
  logic [LW-1:0]   out_seg_length_r;

  assign accept   = start && !busy;
  assign busy     = (state_r != nsra_pkg::S_IDLE);
  assign id_idx   = SW'(id_r);
  assign id_ok    = (32'(id_r) < 32'(MAX_SEGS));
  assign vbit     = id_ok && seg_valid_r[id_idx];
  assign ram_addr = (state_r == nsra_pkg::S_IDLE) ? SW'(in_seg_id) : id_idx;
  assign head     = cells_q[0];
  assign e_w      = EW'(s_r) + EW'(l_r);
  assign head_end = EW'(head.start) + EW'(head.len);
  assign prev_end = EW'(prev_r.start) + EW'(prev_r.len);
  assign in_range = (k_r < cnt_r);
  assign left     = (p_r != '0) && (prev_end == EW'(s_r));
  assign right    = hit_r && (e_w == EW'(nxt_r.start));

  nsra_ram #(
    .WIDTH($bits(nsra_pkg::ent_t)),
    .DEPTH(MAX_SEGS)
  ) u_seg_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(nsra_pkg::ent_t'{start: s_r, len: l_r}),
    .rdata(ram_rdata)
  );

  for (genvar i = 0; i < MAX_FREE; i++) begin : g_cell
    nsra_cell #(
      .IDX     (i),
      .HAS_INIT(i == 0)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .from_prev(cells_q[(i + MAX_FREE - 1) % MAX_FREE]),
      .from_next(cells_q[(i + 1) % MAX_FREE]),
      .ent_r    (cells_q[i])
    );
  end

  // early checks on the identifier and length
  always_comb begin
    priority if (!id_ok) begin
      early_st = nsra_pkg::ST_UNKNOWN;
    end else if (!mode_r && vbit) begin
      early_st = nsra_pkg::ST_INUSE;
    end else if (!mode_r && l_r == '0) begin
      early_st = nsra_pkg::ST_NOFIT;
    end else if (mode_r && !vbit) begin
      early_st = nsra_pkg::ST_UNKNOWN;
    end else begin
      early_st = nsra_pkg::ST_OK;
    end
  end

  // next state and cell update decision
  always_comb begin
    state_nxt      = state_r;
    ctrl           = '0;
    ctrl.rotate    = (state_r == nsra_pkg::S_SCAN);
    ram_we         = 1'b0;
    dec_st         = nsra_pkg::ST_OK;
    cnt_nxt        = cnt_r;
    unique case (state_r)
      nsra_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = nsra_pkg::S_LOOKUP;
        end
      end
      nsra_pkg::S_LOOKUP: begin
        state_nxt = (early_st == nsra_pkg::ST_OK) ? nsra_pkg::S_SCAN : nsra_pkg::S_IDLE;
      end
      nsra_pkg::S_SCAN: begin
        if (k_r == KLAST) begin
          state_nxt = nsra_pkg::S_APPLY;
        end
      end
      nsra_pkg::S_APPLY: begin
        state_nxt = nsra_pkg::S_IDLE;
        if (!mode_r) begin
          priority if (!hit_r) begin
            dec_st = nsra_pkg::ST_NOFIT;
          end else if (s_r == fs_r && e_w == fe_r) begin
            ctrl.shift     = nsra_pkg::SH_DROP;
            ctrl.shift_idx = IW'(p_r);
            cnt_nxt        = cnt_r - CW'(1);
          end else if (s_r == fs_r) begin
            ctrl.mod_en  = 1'b1;
            ctrl.mod_idx = IW'(p_r);
            ctrl.mod_val = '{start: AW'(e_w), len: LW'(fe_r - e_w)};
          end else if (e_w == fe_r) begin
            ctrl.mod_en  = 1'b1;
            ctrl.mod_idx = IW'(p_r);
            ctrl.mod_val = '{start: fs_r, len: LW'(s_r - fs_r)};
          end else if (cnt_r >= CMAX) begin
            dec_st = nsra_pkg::ST_FULL;
          end else begin
            ctrl.mod_en    = 1'b1;
            ctrl.mod_idx   = IW'(p_r);
            ctrl.mod_val   = '{start: fs_r, len: LW'(s_r - fs_r)};
            ctrl.shift     = nsra_pkg::SH_INS;
            ctrl.shift_idx = IW'(p_r) + IW'(1);
            ctrl.ins_val   = '{start: AW'(e_w), len: LW'(fe_r - e_w)};
            cnt_nxt        = cnt_r + CW'(1);
          end
        end else begin
          priority if (left && right) begin
            ctrl.mod_en    = 1'b1;
            ctrl.mod_idx   = IW'(p_r - CW'(1));
            ctrl.mod_val   = '{start: prev_r.start, len: prev_r.len + l_r + nxt_r.len};
            ctrl.shift     = nsra_pkg::SH_DROP;
            ctrl.shift_idx = IW'(p_r);
            cnt_nxt        = cnt_r - CW'(1);
          end else if (left) begin
            ctrl.mod_en  = 1'b1;
            ctrl.mod_idx = IW'(p_r - CW'(1));
            ctrl.mod_val = '{start: prev_r.start, len: prev_r.len + l_r};
          end else if (right) begin
            ctrl.mod_en  = 1'b1;
            ctrl.mod_idx = IW'(p_r);
            ctrl.mod_val = '{start: s_r, len: nxt_r.len + l_r};
          end else if (cnt_r >= CMAX) begin
            dec_st = nsra_pkg::ST_FULL;
          end else begin
            ctrl.shift     = nsra_pkg::SH_INS;
            ctrl.shift_idx = IW'(p_r);
            ctrl.ins_val   = '{start: s_r, len: l_r};
            cnt_nxt        = cnt_r + CW'(1);
          end
        end
        if (dec_st != nsra_pkg::ST_OK) begin
          cnt_nxt = cnt_r;
        end
        ctrl.apply = (dec_st == nsra_pkg::ST_OK);
        ram_we     = (dec_st == nsra_pkg::ST_OK) && !mode_r;
      end
      default: begin
        state_nxt = nsra_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nsra_pkg::S_IDLE;
      cnt_r        <= CW'(1);
      seg_valid_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= 1'b0;
      if (state_r == nsra_pkg::S_LOOKUP && early_st != nsra_pkg::ST_OK) begin
        out_strobe_r <= 1'b1;
      end
      if (state_r == nsra_pkg::S_APPLY) begin
        out_strobe_r <= 1'b1;
        if (dec_st == nsra_pkg::ST_OK) begin
          seg_valid_r[id_idx] <= !mode_r;
        end
      end
    end
  end

  // request and scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      id_r   <= in_seg_id;
      s_r    <= in_base;
      l_r    <= in_length;
    end
    if (state_r == nsra_pkg::S_LOOKUP) begin
      if (mode_r) begin
        s_r <= ram_rdata.start;
        l_r <= ram_rdata.len;
      end
      hit_r <= 1'b0;
      p_r   <= cnt_r;
      k_r   <= '0;
    end
    if (state_r == nsra_pkg::S_SCAN) begin
      k_r <= k_r + CW'(1);
      if (!hit_r && in_range) begin
        if (!mode_r) begin
          if (head.start <= s_r && e_w <= head_end) begin
            hit_r <= 1'b1;
            p_r   <= k_r;
            fs_r  <= head.start;
            fe_r  <= head_end;
          end
        end else if (head.start < s_r) begin
          prev_r <= head;
        end else begin
          hit_r <= 1'b1;
          p_r   <= k_r;
          nxt_r <= head;
        end
      end
    end
    if (state_r == nsra_pkg::S_LOOKUP) begin
      out_status_r     <= early_st;
      out_seg_base_r   <= '0;
      out_seg_length_r <= '0;
    end
    if (state_r == nsra_pkg::S_APPLY) begin
      out_status_r     <= dec_st;
      out_seg_base_r   <= (dec_st == nsra_pkg::ST_OK) ? s_r : '0;
      out_seg_length_r <= (dec_st == nsra_pkg::ST_OK) ? l_r : '0;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_seg_base   = out_seg_base_r;
  assign out_seg_length = out_seg_length_r;

  `NSRA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CMAX && cnt_r != '0 || cnt_r == '0)
  `NSRA_ASSERT_NEXT(a_scan_end, state_r == nsra_pkg::S_SCAN && k_r == KLAST, state_r == nsra_pkg::S_APPLY)
  `NSRA_ASSERT_IMPL(a_ok_len, out_strobe_r && out_status_r == nsra_pkg::ST_OK, out_seg_length_r != '0)
  `NSRA_ASSERT_IMPL(a_cnt_apply, cnt_r != $past(cnt_r), $past(state_r) == nsra_pkg::S_APPLY)

endmodule
`default_nettype wire

/* verif/nsra_checker.sv */
// checker for the segment range allocator: predicts each result beat and compares it
`default_nettype none
module nsra_checker
  import nsra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic              in_mode,
  input  wire logic [ID_W-1:0]   in_seg_id,
  input  wire logic [ADDR_W-1:0] in_base,
  input  wire logic [LEN_W-1:0]  in_length,
  input  wire logic              out_strobe,
  input  wire logic [2:0]        out_status,
  input  wire logic [ADDR_W-1:0] out_seg_base,
  input  wire logic [LEN_W-1:0]  out_seg_length,
  output int                     mismatches,
  output int                     pending,
  output int                     granted,
  output int                     refused
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           st;
    logic [ADDR_W-1:0] b;
    logic [LEN_W-1:0]  l;
  } reply_t;

  int     hole_start[MAX_FREE_DEF];
  int     hole_len[MAX_FREE_DEF];
  int     hole_count;
  int     owned_start[MAX_SEGS_DEF];
  int     owned_len[MAX_SEGS_DEF];
  bit     owned[MAX_SEGS_DEF];
  reply_t awaited_replies[$];

  function automatic void clear_tables();
    hole_count = 1;
    hole_start[0] = 0;
    hole_len[0] = MEM_WORDS;
    for (int k = 0; k < MAX_SEGS_DEF; k++) owned[k] = 1'b0;
  endfunction

  function automatic void drop_hole(int p);
    for (int k = p; k + 1 < hole_count; k++) begin
      hole_start[k] = hole_start[k+1];
      hole_len[k] = hole_len[k+1];
    end
    hole_count--;
  endfunction

  function automatic void add_hole(int p, int s, int l);
    for (int k = hole_count; k > p; k--) begin
      hole_start[k] = hole_start[k-1];
      hole_len[k] = hole_len[k-1];
    end
    hole_start[p] = s;
    hole_len[p] = l;
    hole_count++;
  endfunction

  function automatic status_t carve(int id, int s, int l);
    int i;
    int e;
    int hs;
    int he;
    if (owned[id]) return ST_INUSE;
    if (l == 0) return ST_NOFIT;
    e = s + l;
    i = 0;
    while (i < hole_count && !(hole_start[i] <= s && e <= hole_start[i] + hole_len[i])) i++;
    if (i >= hole_count) return ST_NOFIT;
    hs = hole_start[i];
    he = hs + hole_len[i];
    if (s == hs && e == he) begin
      drop_hole(i);
    end else if (s == hs) begin
      hole_start[i] = e;
      hole_len[i] = he - e;
    end else if (e == he) begin
      hole_len[i] = s - hs;
    end else begin
      if (hole_count >= MAX_FREE_DEF) return ST_FULL;
      hole_len[i] = s - hs;
      add_hole(i + 1, e, he - e);
    end
    owned_start[id] = s;
    owned_len[id] = l;
    owned[id] = 1'b1;
    return ST_OK;
  endfunction

  function automatic status_t give_back(int id);
    int  s;
    int  l;
    int  p;
    bit  lt;
    bit  rt;
    if (!owned[id]) return ST_UNKNOWN;
    s = owned_start[id];
    l = owned_len[id];
    p = 0;
    while (p < hole_count && hole_start[p] < s) p++;
    lt = p > 0 && hole_start[p-1] + hole_len[p-1] == s;
    rt = p < hole_count && s + l == hole_start[p];
    if (lt && rt) begin
      hole_len[p-1] += l + hole_len[p];
      drop_hole(p);
    end else if (lt) begin
      hole_len[p-1] += l;
    end else if (rt) begin
      hole_start[p] = s;
      hole_len[p] += l;
    end else begin
      if (hole_count >= MAX_FREE_DEF) return ST_FULL;
      add_hole(p, s, l);
    end
    owned[id] = 1'b0;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(bit mode, int id, int b, int l);
    reply_t r;
    if (id >= MAX_SEGS_DEF) r.st = ST_UNKNOWN;
    else if (!mode) r.st = carve(id, b, l);
    else r.st = give_back(id);
    r.b = '0;
    r.l = '0;
    if (r.st == ST_OK) begin
      r.b = owned_start[id][ADDR_W-1:0];
      r.l = owned_len[id][LEN_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_tables();
      awaited_replies.delete();
      mismatches <= 0;
      granted <= 0;
      refused <= 0;
      pending <= 0;
    end else begin
      if (start && !busy)
        awaited_replies.push_back(predict_reply(in_mode, in_seg_id, in_base, in_length));
      if (out_strobe) begin
        if (awaited_replies.size() == 0) begin
          if (mismatches < 10) $display("%0t: result beat with nothing awaited", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_replies.pop_front();
          if (want.st == ST_OK) granted <= granted + 1;
          else refused <= refused + 1;
          if (out_status !== want.st || out_seg_base !== want.b || out_seg_length !== want.l) begin
            if (mismatches < 10)
              $display("%0t: mismatch status %0d/%0d base %0d/%0d length %0d/%0d (exp/act)",
                       $realtime, want.st, out_status, want.b, out_seg_base,
                       want.l, out_seg_length);
            mismatches <= mismatches + 1;
          end
        end
      end
      pending <= awaited_replies.size();
    end
  end
endmodule
`default_nettype wire

/* verif/tb_named_segment_range_allocator.sv */
// testbench top for the segment range allocator: stimulus, watchdog and verdict
`default_nettype none
module tb_named_segment_range_allocator;
  import nsra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_mode = 1'b0;
  logic [ID_W-1:0]   in_seg_id = '0;
  logic [ADDR_W-1:0] in_base = '0;
  logic [LEN_W-1:0]  in_length = '0;
  logic              out_strobe;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_seg_base;
  logic [LEN_W-1:0]  out_seg_length;
  int                mismatches;
  int                pending;
  int                granted;
  int                refused;
  int                quiet_cycles = 0;
  int                n_creates = 0;
  int                n_removes = 0;
  bit                calm = 1'b0;

  always #5 clk = ~clk;

  named_segment_range_allocator dut (.*);

  nsra_checker u_checker (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // drive one request beat and hold it until taken
  task automatic issue(bit mode, int id, int b, int l);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 22) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_seg_id <= id[ID_W-1:0];
    in_base <= b[ADDR_W-1:0];
    in_length <= l[LEN_W-1:0];
    if (mode) n_removes++;
    else n_creates++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int l;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(0, 0, 0, MEM_WORDS);
    issue(0, 0, 0, 1);
    issue(1, 0, 0, 0);
    issue(1, 0, 1023, 2047);
    issue(0, 1, 5, 0);
    issue(0, 1, 1000, 100);
    issue(0, 2, 0, 2047);
    issue(0, 3, 1023, 1);
    issue(1, 3, 0, 0);
    for (int k = 0; k < 16; k++) issue(0, k, 64 * k + 10, 5);
    drain();

    for (int n = 0; n < 400; n++) begin
      calm = n >= 100 && n < 180;
      if (n == 250) drain();
      if ($urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0:       l = $urandom_range(0, 2047);
          1:       l = $urandom_range(200, 1024);
          default: l = $urandom_range(1, 48);
        endcase
        issue(0, $urandom_range(15), $urandom_range(1023), l);
      end else begin
        issue(1, $urandom_range(15), $urandom_range(1023), $urandom_range(2047));
      end
    end
    drain();
    repeat (40) @(posedge clk);

    $display("%0d creates and %0d removes issued, %0d granted and %0d refused",
             n_creates, n_removes, granted, refused);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/nsra_pkg.sv
rtl/core/nsra_ram.sv
rtl/core/nsra_cell.sv
rtl/core/named_segment_range_allocator.sv
verif/nsra_checker.sv
verif/tb_named_segment_range_allocator.sv
